[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/kclc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kclc_pkg;

   // Configuration port geometry and register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOGIN_TIMEOUT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_CODE  = 1'd1;

   // Register values after reset.
   localparam logic [15:0] LOGIN_TIMEOUT_RESET = 16'd5000;
   localparam logic [15:0] DEFAULT_CODE_RESET  = 16'h1234;

   // Input item kinds.
   localparam logic [1:0] FUNC_KEY     = 2'd0;
   localparam logic [1:0] FUNC_TICK    = 2'd1;
   localparam logic [1:0] FUNC_FACTORY = 2'd2;

   // Key codes.
   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_ERASE     = 4'd10;
   localparam logic [3:0] KEY_CONFIRM   = 4'd11;

   localparam logic [15:0] TIMER_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_DIGIT      = 3'd1,
      EV_ERASED     = 3'd2,
      EV_LOGIN_OK   = 3'd3,
      EV_LOGIN_FAIL = 3'd4,
      EV_TIMEOUT    = 3'd5,
      EV_CHANGED    = 3'd6,
      EV_RESET      = 3'd7
   } kclc_event_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [15:0] default_code;
   } kclc_cfg_type;

   typedef struct packed {
      kclc_event_type event_res;
      logic           unlocked;
      logic [2:0]     digits_entered;
      logic           seg_write;
      logic [1:0]     seg_pos;
      logic [6:0]     seg_pattern;
      logic           clear_display;
   } kclc_result_type;

   // Seven-segment pattern of a decimal digit; other codes blank.
   function automatic logic [6:0] seg_of_digit(input logic [3:0] digit);
      logic [6:0] pat;
      unique case (digit)
         4'd0:    pat = 7'h3F;
         4'd1:    pat = 7'h06;
         4'd2:    pat = 7'h5B;
         4'd3:    pat = 7'h4F;
         4'd4:    pat = 7'h66;
         4'd5:    pat = 7'h6D;
         4'd6:    pat = 7'h7D;
         4'd7:    pat = 7'h07;
         4'd8:    pat = 7'h7F;
         4'd9:    pat = 7'h6F;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

[rtl/kclc_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Key, tick and factory-reset items into the lock.
interface kclc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [3:0] key_code;

   modport source (output valid, output func, output key_code, input ready);
   modport sink   (input valid, input func, input key_code, output ready);
endinterface

`default_nettype wire

[rtl/kclc_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Result items out of the lock.
interface kclc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic       unlocked;
   logic [2:0] digits_entered;
   logic       seg_write;
   logic [1:0] seg_pos;
   logic [6:0] seg_pattern;
   logic       clear_display;

   modport source (output valid, output event_res, output unlocked, output digits_entered,
                   output seg_write, output seg_pos, output seg_pattern,
                   output clear_display, input ready);
   modport sink   (input valid, input event_res, input unlocked, input digits_entered,
                   input seg_write, input seg_pos, input seg_pattern,
                   input clear_display, output ready);
endinterface

`default_nettype wire

[rtl/kclc_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Lock state and its update for one item.
module kclc_engine #(
   parameter int unsigned CODE_LENGTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire logic [1:0]               func,
   input  wire logic [3:0]               key_code,
   input  wire kclc_pkg::kclc_cfg_type   cfg,
   output kclc_pkg::kclc_result_type     result
);
   import kclc_pkg::*;

   localparam int unsigned CW = $clog2(CODE_LENGTH + 1);
   localparam int unsigned IW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam logic [CW-1:0] FULL = CW'(CODE_LENGTH);

   // Digit i of a code word; the first digit sits in the top used nibble.
   function automatic logic [3:0] code_digit(input logic [15:0] code, input int unsigned pos);
      int unsigned sh;
      sh = (CODE_LENGTH - 1 - pos) * 4;
      if (sh < 16) begin
         return 4'(code >> sh);
      end
      return 4'd0;
   endfunction

   logic [3:0]    entry_digits_ff [CODE_LENGTH];
   logic [3:0]    entry_digits_in [CODE_LENGTH];
   logic [3:0]    stored_code_ff  [CODE_LENGTH];
   logic [3:0]    stored_code_in  [CODE_LENGTH];
   logic [CW-1:0] entry_count_ff;
   logic [CW-1:0] entry_count_in;
   logic          logged_in_ff;
   logic          logged_in_in;
   logic [15:0]   login_timer_ff;
   logic [15:0]   login_timer_in;

   logic          match;
   logic [CW-1:0] count_inc;
   logic [CW-1:0] count_dec;
   logic [15:0]   timer_inc;

   // The last digit arrives with the key; the others are already held.
   always_comb begin
      match = (key_code == stored_code_ff[CODE_LENGTH-1]);
      for (int i = 0; i < CODE_LENGTH - 1; i++) begin
         if (entry_digits_ff[i] != stored_code_ff[i]) begin
            match = 1'b0;
         end
      end
   end

   assign count_inc = entry_count_ff + 1'b1;
   assign count_dec = entry_count_ff - 1'b1;
   assign timer_inc = (login_timer_ff != TIMER_MAX) ? login_timer_ff + 16'd1 : login_timer_ff;

   // Next state and the result item.
   always_comb begin
      entry_digits_in = entry_digits_ff;
      stored_code_in  = stored_code_ff;
      entry_count_in  = entry_count_ff;
      logged_in_in    = logged_in_ff;
      login_timer_in  = login_timer_ff;
      result          = '0;
      result.event_res = EV_NONE;

      unique case (func)
         FUNC_KEY: begin
            if (key_code <= KEY_DIGIT_MAX) begin
               if (entry_count_ff < FULL) begin
                  entry_digits_in[entry_count_ff[IW-1:0]] = key_code;
                  entry_count_in     = count_inc;
                  result.seg_write   = 1'b1;
                  result.seg_pos     = 2'(entry_count_ff);
                  result.seg_pattern = seg_of_digit(key_code);
                  result.event_res   = EV_DIGIT;
                  // A full entry while logged out is checked at once.
                  if (count_inc == FULL && !logged_in_ff) begin
                     if (match) begin
                        logged_in_in     = 1'b1;
                        login_timer_in   = 16'd0;
                        result.event_res = EV_LOGIN_OK;
                     end else begin
                        result.event_res = EV_LOGIN_FAIL;
                     end
                     for (int i = 0; i < CODE_LENGTH; i++) begin
                        entry_digits_in[i] = 4'd0;
                     end
                     entry_count_in       = '0;
                     result.clear_display = 1'b1;
                  end
               end
            end else if (key_code == KEY_ERASE) begin
               if (entry_count_ff != '0) begin
                  entry_digits_in[count_dec[IW-1:0]] = 4'd0;
                  entry_count_in   = count_dec;
                  result.seg_write = 1'b1;
                  result.seg_pos   = 2'(count_dec);
                  result.event_res = EV_ERASED;
               end
            end else if (key_code == KEY_CONFIRM) begin
               // A full entry while logged in becomes the new code.
               if (logged_in_ff && entry_count_ff == FULL) begin
                  stored_code_in = entry_digits_ff;
                  logged_in_in   = 1'b0;
                  for (int i = 0; i < CODE_LENGTH; i++) begin
                     entry_digits_in[i] = 4'd0;
                  end
                  entry_count_in       = '0;
                  result.clear_display = 1'b1;
                  result.event_res     = EV_CHANGED;
               end
            end
         end
         FUNC_TICK: begin
            if (logged_in_ff) begin
               login_timer_in = timer_inc;
               if (timer_inc >= cfg.timeout_ticks) begin
                  logged_in_in = 1'b0;
                  for (int i = 0; i < CODE_LENGTH; i++) begin
                     entry_digits_in[i] = 4'd0;
                  end
                  entry_count_in       = '0;
                  result.clear_display = 1'b1;
                  result.event_res     = EV_TIMEOUT;
               end
            end
         end
         FUNC_FACTORY: begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
               stored_code_in[i]  = code_digit(cfg.default_code, i);
               entry_digits_in[i] = 4'd0;
            end
            entry_count_in       = '0;
            logged_in_in         = 1'b0;
            login_timer_in       = 16'd0;
            result.clear_display = 1'b1;
            result.event_res     = EV_RESET;
         end
         default: begin
            // Unused item kind: no change.
         end
      endcase

      result.unlocked       = logged_in_in;
      result.digits_entered = 3'(entry_count_in);
   end

   // State registers, updated when the item moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CODE_LENGTH; i++) begin
            entry_digits_ff[i] <= 4'd0;
            stored_code_ff[i]  <= code_digit(DEFAULT_CODE_RESET, i);
         end
         entry_count_ff <= '0;
         logged_in_ff   <= 1'b0;
         login_timer_ff <= 16'd0;
      end else if (fire) begin
         entry_digits_ff <= entry_digits_in;
         stored_code_ff  <= stored_code_in;
         entry_count_ff  <= entry_count_in;
         logged_in_ff    <= logged_in_in;
         login_timer_ff  <= login_timer_in;
      end
   end

endmodule

`default_nettype wire

[rtl/keypad_code_lock_controller.sv]
// Keypad code lock: one item in, one result item out.
// An accepted item passes through the input register, then the result register, with the
// state update between the two. Throughput: one item per cycle while rsp is not held; the
// result register stalls only while rsp is held.
// Reset (synchronous, active high) clears the entry, logs out, clears the timer,
// restores the code from the reset default and sets the registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_lock_controller #(
   parameter int unsigned CODE_LENGTH = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   kclc_req_if.sink                               req,
   kclc_rsp_if.source                             rsp,
   input  wire logic                              csr_write_en,
   input  wire logic [kclc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [kclc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kclc_pkg::*;

   kclc_cfg_type    cfg_ff;
   logic            in_valid_ff;
   logic [1:0]      in_func_ff;
   logic [3:0]      in_key_ff;
   logic            rsp_valid_ff;
   kclc_result_type rsp_res_ff;
   kclc_result_type result;
   logic            advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= LOGIN_TIMEOUT_RESET;
         cfg_ff.default_code  <= DEFAULT_CODE_RESET;
      end else if (csr_write_en) begin
         if (csr_index == CSR_LOGIN_TIMEOUT) begin
            cfg_ff.timeout_ticks <= csr_wdata;
         end
         if (csr_index == CSR_DEFAULT_CODE) begin
            cfg_ff.default_code <= csr_wdata;
         end
      end
   end

   // The held item moves on when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_func_ff <= req.func;
         in_key_ff  <= req.key_code;
      end
   end

   kclc_engine #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .func     (in_func_ff),
      .key_code (in_key_ff),
      .cfg      (cfg_ff),
      .result   (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_res_ff <= result;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.event_res      = rsp_res_ff.event_res;
   assign rsp.unlocked       = rsp_res_ff.unlocked;
   assign rsp.digits_entered = rsp_res_ff.digits_entered;
   assign rsp.seg_write      = rsp_res_ff.seg_write;
   assign rsp.seg_pos        = rsp_res_ff.seg_pos;
   assign rsp.seg_pattern    = rsp_res_ff.seg_pattern;
   assign rsp.clear_display  = rsp_res_ff.clear_display;

endmodule

`default_nettype wire

[rtl/kclc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Port-level checks of the lock.
module kclc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] event_res,
   input wire logic       unlocked,
   input wire logic [2:0] digits_entered,
   input wire logic       seg_write,
   input wire logic [1:0] seg_pos,
   input wire logic [6:0] seg_pattern,
   input wire logic       clear_display
);
   import kclc_pkg::*;

   logic [17:0] payload;
   logic        stall;
   logic        clear_ok;
   logic        level_ok;
   logic        seg_idle_ok;

   // Everything a result item carries, and whether it is held back.
   assign payload = {event_res, unlocked, digits_entered, seg_write, seg_pos, seg_pattern,
                     clear_display};
   assign stall   = rsp_valid && !rsp_ready;

   // Clearing the display always comes with an empty entry.
   assign clear_ok = !clear_display || (digits_entered == 3'd0);

   // Login opens the lock; failure, timeout, change and factory reset leave it shut.
   assign level_ok = (event_res == EV_LOGIN_OK) ? unlocked :
                     (event_res == EV_LOGIN_FAIL || event_res == EV_TIMEOUT ||
                      event_res == EV_CHANGED || event_res == EV_RESET) ? !unlocked : 1'b1;

   // Without a display write the position and pattern are zero.
   assign seg_idle_ok = seg_write || (seg_pos == 2'd0 && seg_pattern == 7'd0);

   // A stalled result holds still.
   `ASSERT_CLKD(a_rsp_hold, clock, reset, stall |=> rsp_valid && $stable(payload), "held result changed")

   // No result is shown in the cycle after reset.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   `ASSERT_CLKD(a_clear_empty, clock, reset, rsp_valid |-> clear_ok, "display cleared with digits held")

   `ASSERT_CLKD(a_unlock_level, clock, reset, rsp_valid |-> level_ok, "unlock level wrong for event")

   `ASSERT_CLKD(a_seg_idle, clock, reset, rsp_valid |-> seg_idle_ok, "idle display write not zero")

endmodule

bind keypad_code_lock_controller kclc_checker u_kclc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .event_res      (rsp.event_res),
   .unlocked       (rsp.unlocked),
   .digits_entered (rsp.digits_entered),
   .seg_write      (rsp.seg_write),
   .seg_pos        (rsp.seg_pos),
   .seg_pattern    (rsp.seg_pattern),
   .clear_display  (rsp.clear_display)
);

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import kclc_pkg::*;

   localparam int unsigned CODE_LEN    = 4;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned PHASE_ITEMS = 230;

   // Seven-segment glyphs of the decimal digits.
   localparam logic [6:0] DIGIT_GLYPH [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   kclc_req_if req_ch ();
   kclc_rsp_if rsp_ch ();

   keypad_code_lock_controller dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Lock state as the testbench expects it.
   logic [15:0] cfg_timeout = LOGIN_TIMEOUT_RESET;
   logic [15:0] cfg_default = DEFAULT_CODE_RESET;
   logic [0:CODE_LEN-1][3:0] entry_buf = '0;
   logic [2:0] entry_len = '0;
   logic [0:CODE_LEN-1][3:0] pin_code = DEFAULT_CODE_RESET;
   logic door_open = 1'b0;
   logic [15:0] unlock_ticks = '0;

   kclc_result_type pending_results [$];

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned err_count = 0;
   int unsigned items_sent = 0;
   int unsigned effective_items = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used = 0;
   int unsigned event_tally [8] = '{default: 0};
   int unsigned quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Works out the result of one item and advances the expected lock state.
   function automatic kclc_result_type next_lock_result(input logic [1:0] func,
                                                        input logic [3:0] key);
      kclc_result_type r;
      r = '0;
      r.event_res = EV_NONE;
      case (func)
         FUNC_KEY: begin
            if (key <= KEY_DIGIT_MAX) begin
               if (entry_len < CODE_LEN) begin
                  entry_buf[entry_len] = key;
                  r.seg_write = 1'b1;
                  r.seg_pos = entry_len[1:0];
                  r.seg_pattern = DIGIT_GLYPH[key];
                  entry_len++;
                  r.event_res = EV_DIGIT;
                  // A full entry while locked is checked against the PIN at once.
                  if (entry_len == CODE_LEN && !door_open) begin
                     if (entry_buf == pin_code) begin
                        door_open = 1'b1;
                        unlock_ticks = '0;
                        r.event_res = EV_LOGIN_OK;
                     end else begin
                        r.event_res = EV_LOGIN_FAIL;
                     end
                     entry_buf = '0;
                     entry_len = '0;
                     r.clear_display = 1'b1;
                  end
               end
            end else if (key == KEY_ERASE) begin
               if (entry_len > 0) begin
                  entry_len--;
                  entry_buf[entry_len] = '0;
                  r.seg_write = 1'b1;
                  r.seg_pos = entry_len[1:0];
                  r.event_res = EV_ERASED;
               end
            end else if (key == KEY_CONFIRM) begin
               if (door_open && entry_len == CODE_LEN) begin
                  pin_code = entry_buf;
                  door_open = 1'b0;
                  entry_buf = '0;
                  entry_len = '0;
                  r.clear_display = 1'b1;
                  r.event_res = EV_CHANGED;
               end
            end
         end
         FUNC_TICK: begin
            if (door_open) begin
               if (unlock_ticks != TIMER_MAX) unlock_ticks++;
               if (unlock_ticks >= cfg_timeout) begin
                  door_open = 1'b0;
                  entry_buf = '0;
                  entry_len = '0;
                  r.clear_display = 1'b1;
                  r.event_res = EV_TIMEOUT;
               end
            end
         end
         FUNC_FACTORY: begin
            pin_code = cfg_default;
            entry_buf = '0;
            entry_len = '0;
            door_open = 1'b0;
            unlock_ticks = '0;
            r.clear_display = 1'b1;
            r.event_res = EV_RESET;
         end
         default: ;
      endcase
      r.unlocked = door_open;
      r.digits_entered = entry_len;
      return r;
   endfunction

   // Sends one item, waits for it to be taken and queues its expected result.
   task automatic send_item(input logic [1:0] func, input logic [3:0] key);
      logic was_open;
      kclc_result_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= func;
      req_ch.key_code <= key;
      do @(posedge clock); while (!req_ch.ready);
      was_open = door_open;
      r = next_lock_result(func, key);
      pending_results.push_back(r);
      items_sent++;
      event_tally[r.event_res]++;
      if (r.event_res != EV_NONE || (func == FUNC_TICK && was_open)) effective_items++;
   endtask

   // Stops sending and waits until every expected result has arrived.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Writes both registers while the lock is idle.
   task automatic apply_settings(input logic [15:0] timeout, input logic [15:0] code);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_LOGIN_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_index <= CSR_DEFAULT_CODE;
      csr_wdata <= code;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_timeout = timeout;
      cfg_default = code;
      settings_used++;
   endtask

   function automatic logic [15:0] random_bcd();
      logic [15:0] v;
      for (int i = 0; i < 4; i++) v[i*4 +: 4] = 4'($urandom_range(9));
      return v;
   endfunction

   task automatic enter_digits(input logic [0:CODE_LEN-1][3:0] code);
      for (int i = 0; i < CODE_LEN; i++) send_item(FUNC_KEY, code[i]);
   endtask

   task automatic erase_all();
      while (entry_len > 0) send_item(FUNC_KEY, KEY_ERASE);
   endtask

   task automatic send_noise();
      int unsigned n;
      n = $urandom_range(1, 3);
      repeat (n) send_item(2'($urandom_range(3)), 4'($urandom_range(15)));
   endtask

   // A few digits, then some erases.
   task automatic send_partial_entry();
      int unsigned n;
      int unsigned m;
      n = $urandom_range(1, 3);
      m = $urandom_range(0, n + 1);
      repeat (n) send_item(FUNC_KEY, 4'($urandom_range(9)));
      repeat (m) send_item(FUNC_KEY, KEY_ERASE);
   endtask

   // One random sequence, mostly well formed for the current lock state.
   task automatic run_random_sequence();
      int unsigned pick;
      int unsigned n;
      logic [0:CODE_LEN-1][3:0] code;
      pick = $urandom_range(99);
      for (int i = 0; i < CODE_LEN; i++) code[i] = 4'($urandom_range(9));
      if (!door_open) begin
         if (pick < 45) begin
            // Correct PIN, sometimes with a mistyped digit that is erased again.
            erase_all();
            if ($urandom_range(3) == 0) begin
               n = $urandom_range(CODE_LEN - 2);
               for (int i = 0; i < n; i++) send_item(FUNC_KEY, pin_code[i]);
               send_item(FUNC_KEY, 4'($urandom_range(9)));
               send_item(FUNC_KEY, KEY_ERASE);
               for (int i = n; i < CODE_LEN; i++) send_item(FUNC_KEY, pin_code[i]);
            end else begin
               enter_digits(pin_code);
            end
         end else if (pick < 70) begin
            erase_all();
            enter_digits(code);
         end else if (pick < 80) begin
            send_partial_entry();
         end else if (pick < 87) begin
            send_item(FUNC_FACTORY, 4'($urandom_range(15)));
         end else begin
            send_noise();
         end
      end else begin
         if (pick < 30) begin
            // New PIN, with an early confirm or an extra digit now and then.
            erase_all();
            for (int i = 0; i < CODE_LEN; i++) begin
               if (i == CODE_LEN - 1 && $urandom_range(3) == 0)
                  send_item(FUNC_KEY, KEY_CONFIRM);
               send_item(FUNC_KEY, code[i]);
            end
            if ($urandom_range(3) == 0) send_item(FUNC_KEY, 4'($urandom_range(9)));
            send_item(FUNC_KEY, KEY_CONFIRM);
         end else if (pick < 60) begin
            n = $urandom_range(1, 12);
            repeat (n) send_item(FUNC_TICK, 4'($urandom_range(15)));
         end else if (pick < 72) begin
            send_partial_entry();
         end else if (pick < 80) begin
            send_item(FUNC_FACTORY, 4'($urandom_range(15)));
         end else begin
            send_noise();
         end
      end
   endtask

   // Ignored items, erase, a rejected code, login, PIN change and factory reset.
   task automatic test_login_and_change();
      send_item(FUNC_TICK, 4'd0);
      send_item(FUNC_KEY, KEY_ERASE);
      send_item(FUNC_KEY, KEY_CONFIRM);
      send_item(FUNC_KEY, 4'd12);
      send_item(FUNC_KEY, 4'd15);
      send_item(2'd3, 4'd5);
      send_item(FUNC_KEY, 4'd9);
      send_item(FUNC_KEY, KEY_ERASE);
      enter_digits({4'd1, 4'd2, 4'd3, 4'd5});
      enter_digits({4'd1, 4'd2, 4'd3, 4'd4});
      send_item(FUNC_KEY, 4'd0);
      send_item(FUNC_KEY, 4'd9);
      send_item(FUNC_KEY, 4'd9);
      send_item(FUNC_KEY, KEY_CONFIRM);
      send_item(FUNC_KEY, 4'd0);
      send_item(FUNC_KEY, 4'd7);
      send_item(FUNC_KEY, KEY_CONFIRM);
      enter_digits({4'd0, 4'd9, 4'd9, 4'd0});
      send_item(FUNC_KEY, KEY_ERASE);
      send_item(FUNC_FACTORY, 4'd0);
   endtask

   // Automatic logout at the shortest timeout and at a few ticks.
   task automatic test_login_timeout();
      apply_settings(16'd1, 16'h0000);
      send_item(FUNC_FACTORY, 4'd0);
      enter_digits({4'd0, 4'd0, 4'd0, 4'd0});
      send_item(FUNC_TICK, 4'd0);
      apply_settings(16'd3, 16'h9999);
      send_item(FUNC_FACTORY, 4'd0);
      enter_digits({4'd9, 4'd9, 4'd9, 4'd9});
      repeat (3) send_item(FUNC_TICK, 4'd0);
   endtask

   // Random sequences under one register setting and one idling pattern.
   task automatic test_random_phase(input int unsigned sender_pct, input int unsigned recv_pct,
                                    input logic [15:0] timeout, input logic [15:0] code);
      int unsigned start;
      logic paused;
      apply_settings(timeout, code);
      send_idle_pct = sender_pct;
      stall_pct = recv_pct;
      start = effective_items;
      paused = 1'b0;
      send_item(FUNC_FACTORY, 4'd0);
      while (effective_items - start < PHASE_ITEMS) begin
         run_random_sequence();
         // Halfway through, let the lock drain completely once.
         if (!paused && effective_items - start >= PHASE_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   // Receiver side: ready follows the current stall rate.
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         err_count++;
      end
   endtask

   // Each result taken is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      kclc_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0d ns: unexpected result, event %0d", $time, rsp_ch.event_res);
            err_count++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            report_field("event_res", want.event_res, rsp_ch.event_res);
            report_field("unlocked", want.unlocked, rsp_ch.unlocked);
            report_field("digits_entered", want.digits_entered, rsp_ch.digits_entered);
            report_field("seg_write", want.seg_write, rsp_ch.seg_write);
            report_field("seg_pos", want.seg_pos, rsp_ch.seg_pos);
            report_field("seg_pattern", want.seg_pattern, rsp_ch.seg_pattern);
            report_field("clear_display", want.clear_display, rsp_ch.clear_display);
         end
      end
   end

   // Ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0d ns: no progress for %0d cycles, %0d results outstanding",
                  $time, QUIET_LIMIT, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func <= FUNC_KEY;
      req_ch.key_code <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_LOGIN_TIMEOUT;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_login_and_change();
      test_login_timeout();
      test_random_phase(0, 0, 16'd7, random_bcd());
      test_random_phase(75, 0, 16'd1, 16'h9999);
      test_random_phase(0, 75, TIMER_MAX, 16'h0000);
      test_random_phase(34, 34, 16'($urandom_range(2, 25)), random_bcd());
      test_random_phase(0, 0, 16'($urandom_range(2, 12)), DEFAULT_CODE_RESET);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Sent %0d key, tick and reset items under %0d register settings; %0d results checked.",
               items_sent, settings_used, results_checked);
      $display("Seen: %0d logins, %0d rejected codes, %0d timeouts, %0d PIN changes, %0d resets.",
               event_tally[EV_LOGIN_OK], event_tally[EV_LOGIN_FAIL], event_tally[EV_TIMEOUT],
               event_tally[EV_CHANGED], event_tally[EV_RESET]);
      if (err_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
